// File: src/button_click_classifier_defines.svh
// Assertion macros shared by the button click classifier RTL.
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

`define BCC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bcc assertion failed");

`define BCC_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("bcc forbidden condition");

`else

`define BCC_ASSERT(label, clk, rst_n, prop)

`define BCC_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: src/bcc_pkg.sv
// Shared types and constants of the button click classifier.
package bcc_pkg;

	localparam int unsigned DEB_W     = 8;
	localparam int unsigned GAP_W     = 10;
	localparam int unsigned SAMPLE_W  = 9;
	localparam int unsigned RELEASE_W = 11;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 10;
	localparam int unsigned TDATA_W   = 8;

	localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(20);
	localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(250);

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAP      = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2
	} event_t;

	typedef struct packed {
		logic [DEB_W-1:0] debounce_ticks;
		logic [GAP_W-1:0] double_gap_ticks;
	} cfg_t;

endpackage

// File: src/button_click_classifier.sv
// Top level of the button click classifier: one instance per button.
`include "button_click_classifier_defines.svh"

// Button click classifier. Every transfer on the s_ side is one millisecond
// tick carrying the raw pin level; every tick yields exactly one transfer on
// the m_ side with the event code: none, single press or double press. The
// pin is resampled only after more than debounce_ticks ticks, the held sample
// is the debounced level, and a release either arms a pending press or, if
// one is pending, reports a double press. A pending press becomes a single
// press once more than double_gap_ticks ticks pass with the button up.
// Throughput is one tick per clock unless m_ stalls; a tick passes the input
// register, then the state update and result register. The debounce/click
// state is updated in the cycle a tick moves from the input to the result
// register, so a stall on m_ holds the state as well. A tick is accepted
// while a result still waits on m_ as long as the input register is free.
// Configuration (index 0 debounce_ticks, index 1 double_gap_ticks, others
// ignored) is always ready and should be written only while no tick is in
// flight. Reset values: 20 and 250 ticks.
module button_click_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bcc_pkg::TDATA_W-1:0]   s_tdata,   // [0] pin_level
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bcc_pkg::TDATA_W-1:0]   m_tdata,   // [1:0] click_event
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bcc_pkg::CFG_DAT_W-1:0] cfg_data
);

	bcc_pkg::cfg_t   cfg;
	bcc_pkg::event_t click;

	// input register stage
	logic pin_s1, valid_s1;
	// result register stage
	bcc_pkg::event_t click_s2;
	logic valid_s2;

	logic out_free;   // result register can take a new value this cycle
	logic advance;    // tick moves from input stage into result stage

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	bcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.pin    (pin_s1),
		.cfg    (cfg),
		.click  (click)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pin_s1 <= s_tdata[0];
		end
		if (advance) begin
			click_s2 <= click;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(bcc_pkg::TDATA_W - 2){1'b0}}, click_s2};

	// a tick in the input stage is never dropped while the output stalls
	`BCC_ASSERT(a_s1_held_on_stall, clk, arst_n,
		(valid_s1 && valid_s2 && !m_tready) |=> valid_s1)
	// a tick leaving the input stage always lands in the result stage
	`BCC_ASSERT(a_advance_fills_s2, clk, arst_n, advance |=> valid_s2)
	// with a free input stage the block must take a new tick
	`BCC_ASSERT_NEVER(a_ready_when_empty, clk, arst_n, !valid_s1 && !s_tready)

endmodule

// File: src/bcc_cfg_regs.sv
// Configuration register file of the button click classifier.
module bcc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bcc_pkg::CFG_DAT_W-1:0] cfg_data,
	output bcc_pkg::cfg_t                 cfg
);

	bcc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= bcc_pkg::DEB_RESET;
			cfg_q.double_gap_ticks <= bcc_pkg::GAP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				bcc_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ticks <= cfg_data[bcc_pkg::DEB_W-1:0];
				end
				bcc_pkg::REG_GAP: begin
					cfg_q.double_gap_ticks <= cfg_data[bcc_pkg::GAP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: src/bcc_engine.sv
// Debounce and click state of one button, advanced once per tick.
`include "button_click_classifier_defines.svh"

module bcc_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             pin,
	input  bcc_pkg::cfg_t    cfg,
	output bcc_pkg::event_t  click
);

	localparam logic [bcc_pkg::SAMPLE_W-1:0]  SAMPLE_MAX  = '1;
	localparam logic [bcc_pkg::RELEASE_W-1:0] RELEASE_MAX = '1;

	logic [bcc_pkg::SAMPLE_W-1:0]  since_sample_q, sample_inc, since_sample_d;
	logic [bcc_pkg::RELEASE_W-1:0] since_release_q, release_inc, since_release_d;
	logic held_q, held_d;
	logic pressed_q;
	logic pending_q, pending_d;
	logic take_sample, release_seen;

	always_comb begin
		sample_inc  = (since_sample_q == SAMPLE_MAX) ? SAMPLE_MAX :
			since_sample_q + 1'b1;
		release_inc = (since_release_q == RELEASE_MAX) ? RELEASE_MAX :
			since_release_q + 1'b1;

		take_sample    = sample_inc > {1'b0, cfg.debounce_ticks};
		held_d         = take_sample ? pin : held_q;
		since_sample_d = take_sample ? '0 : sample_inc;

		// pressed -> released edge of the debounced level
		release_seen    = pressed_q && !held_d;
		since_release_d = release_seen ? '0 : release_inc;

		click     = bcc_pkg::EV_NONE;
		pending_d = pending_q;
		if (release_seen) begin
			if (pending_q) begin
				click     = bcc_pkg::EV_DOUBLE;
				pending_d = 1'b0;
			end else begin
				pending_d = 1'b1;
			end
		end

		// gap elapsed with button up: pending press is a single
		if (!held_d && pending_d &&
			since_release_d > {1'b0, cfg.double_gap_ticks}) begin
			click     = bcc_pkg::EV_SINGLE;
			pending_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_sample_q  <= '0;
			since_release_q <= '0;
			held_q          <= 1'b0;
			pressed_q       <= 1'b0;
			pending_q       <= 1'b0;
		end else if (step) begin
			since_sample_q  <= since_sample_d;
			since_release_q <= since_release_d;
			held_q          <= held_d;
			pressed_q       <= held_d;
			pending_q       <= pending_d;
		end
	end

	`BCC_ASSERT(a_double_needs_pending, clk, arst_n,
		(step && click == bcc_pkg::EV_DOUBLE) |-> pending_q)
	`BCC_ASSERT(a_event_clears_pending, clk, arst_n,
		(step && click != bcc_pkg::EV_NONE) |=> !pending_q)
	`BCC_ASSERT(a_event_when_released, clk, arst_n,
		(step && click != bcc_pkg::EV_NONE) |=> !pressed_q)
	`BCC_ASSERT_NEVER(a_pressed_tracks_held, clk, arst_n, pressed_q != held_q)

endmodule

// File: bench/tb_button_click_classifier.sv
// Self-checking testbench for the button click classifier: directed plan, then random clicks.
module tb_button_click_classifier;
	import bcc_pkg::*;

	// Indexes outside the register map; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(255);
	localparam int                   PLAN_ROWS  = 27;
	localparam int                   RAND_PHASES = 6;
	localparam int                   PHASE_TICKS = 40;

	typedef enum logic [0:0] {
		ROW_TICKS = 1'b0,
		ROW_WRITE = 1'b1
	} row_kind_t;

	// One line of the directed plan: either a run of identical ticks or a register write.
	// When typed is set, every tick of the run must give ev.
	typedef struct packed {
		row_kind_t             kind;
		logic                  pin;
		logic [11:0]           count;
		logic                  typed;
		event_t                ev;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DAT_W-1:0]  data;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata;   // [0] pin_level
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;   // [1:0] click_event
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// Expectation carried alongside the tick on the input side
	logic   tick_typed;
	event_t tick_typed_ev;

	// Predictor state and its copy of the registers
	logic [SAMPLE_W-1:0]  smp_cnt;
	logic [RELEASE_W-1:0] rel_cnt;
	logic                 held;
	logic                 pressed;
	logic                 pending;
	logic [DEB_W-1:0]     shadow_deb;
	logic [GAP_W-1:0]     shadow_gap;

	event_t due_events[$];

	int mismatch_cnt = 0;
	int burst_left = 0;
	int rx_cyc = 0;
	int rx_mode = 0;
	int n_ticks = 0;
	int n_single = 0;
	int n_double = 0;
	int n_writes = 0;

	row_t plan [PLAN_ROWS] = '{
		// Right after reset with the default 20 / 250 setting
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b1, 12'd25,   1'b0, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd25,   1'b0, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd260,  1'b0, EV_NONE,   '0, '0},
		// Zero debounce and zero gap: every tick samples
		'{ROW_WRITE, 1'b0, 12'd0,    1'b0, EV_NONE,   REG_DEBOUNCE, 10'd0},
		'{ROW_WRITE, 1'b0, 12'd0,    1'b0, EV_NONE,   REG_GAP,      10'd0},
		// Single press: fires the tick after the release
		'{ROW_TICKS, 1'b1, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_SINGLE, '0, '0},
		// Double press: second release comes before the gap test can run
		'{ROW_TICKS, 1'b1, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b1, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_DOUBLE, '0, '0},
		// Long hold while a press is pending, then the release gives a double
		'{ROW_TICKS, 1'b1, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b1, 12'd10,   1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_DOUBLE, '0, '0},
		// Writes off the map are dropped; zero/zero behavior must hold
		'{ROW_WRITE, 1'b0, 12'd0,    1'b0, EV_NONE,   REG_UNUSED, 10'h155},
		'{ROW_WRITE, 1'b0, 12'd0,    1'b0, EV_NONE,   REG_TOP,    10'h3FF},
		'{ROW_TICKS, 1'b1, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_SINGLE, '0, '0},
		// Debounce keeps only its low byte (0x100 reads as zero), gap at its widest
		'{ROW_WRITE, 1'b0, 12'd0,    1'b0, EV_NONE,   REG_DEBOUNCE, 10'h100},
		'{ROW_WRITE, 1'b0, 12'd0,    1'b0, EV_NONE,   REG_GAP,      10'h3FF},
		'{ROW_TICKS, 1'b1, 12'd1,    1'b1, EV_NONE,   '0, '0},
		'{ROW_TICKS, 1'b0, 12'd1,    1'b1, EV_NONE,   '0, '0},
		// Press stays pending under the wide gap
		'{ROW_TICKS, 1'b0, 12'd3,    1'b1, EV_NONE,   '0, '0}
	};

	button_click_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// One tick of the click detector: counters, resample, release handling, gap test.
	function automatic event_t classify_tick(input logic pin);
		event_t ev;
		ev = EV_NONE;
		if (smp_cnt != '1) smp_cnt = smp_cnt + 1'b1;
		if (rel_cnt != '1) rel_cnt = rel_cnt + 1'b1;
		if (smp_cnt > shadow_deb) begin
			held = pin;
			smp_cnt = '0;
		end
		if (held != pressed) begin
			pressed = held;
			if (!pressed) begin
				rel_cnt = '0;
				if (pending) begin
					ev = EV_DOUBLE;
					pending = 1'b0;
				end else begin
					pending = 1'b1;
				end
			end
		end
		if (!pressed && pending && rel_cnt > shadow_gap) begin
			pending = 1'b0;
			ev = EV_SINGLE;
		end
		return ev;
	endfunction

	// Input side: every accepted tick updates the predictor and queues its event
	always @(posedge clk) begin : tick_monitor
		event_t ev;
		if (arst_n && s_tvalid && s_tready) begin
			ev = classify_tick(s_tdata[0]);
			due_events.push_back(tick_typed ? tick_typed_ev : ev);
			n_ticks++;
		end
	end

	// Output side: compare each transfer with the oldest queued event
	always @(posedge clk) begin : event_checker
		event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_events.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result transfer, click_event %0d", m_tdata[1:0]);
			end else begin
				want = due_events.pop_front();
				if (m_tdata[1:0] !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("click_event mismatch: expected %0d, got %0d",
							want, m_tdata[1:0]);
				end
				if (want == EV_SINGLE) n_single++;
				if (want == EV_DOUBLE) n_double++;
			end
		end
	end

	// Receiver back-pressure in one of four modes, redrawn at random
	// (always ready, coin flip, a regular stall pattern, mostly stalled)
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if (rx_cyc % 128 == 0) rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (rx_cyc % 4 != 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Present one tick and hold it until the transfer; the sender runs in bursts
	// with random gaps, some bursts back to back.
	task automatic send_tick(input logic pin, input logic typed, input event_t ev);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid      <= 1'b1;
		s_tdata       <= {{(TDATA_W-1){1'b0}}, pin};
		tick_typed    <= typed;
		tick_typed_ev <= ev;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop sending and wait until every queued event has come out, plus pipeline slack.
	// It first lets the last accepted tick reach the queue.
	task automatic drain_events();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write while the block is idle; the predictor copy follows at the transfer
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		drain_events();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_DEBOUNCE) shadow_deb = val[DEB_W-1:0];
		else if (idx == REG_GAP) shadow_gap = val[GAP_W-1:0];
		n_writes++;
	endtask

	task automatic send_run(input logic pin, input int len, inout int sent);
		repeat (len) send_tick(pin, 1'b0, EV_NONE);
		sent += len;
	endtask

	initial begin
		int r;
		int ph;
		int deb;
		int gap;
		int sent;
		int len;
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		tick_typed = 1'b0;
		tick_typed_ev = EV_NONE;
		smp_cnt    = '0;
		rel_cnt    = '0;
		held       = 1'b0;
		pressed    = 1'b0;
		pending    = 1'b0;
		shadow_deb = DEB_RESET;
		shadow_gap = GAP_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].kind == ROW_WRITE)
				write_reg(plan[r].idx, plan[r].data);
			else
				repeat (plan[r].count) send_tick(plan[r].pin, plan[r].typed, plan[r].ev);
		end

		// Random part: short debounce and gap so clicks complete within a phase; the
		// last phase's gap is wide. Mostly press/release pairs around gaps, raw pin noise too.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			deb = (ph == 0) ? 0 : $urandom_range(0, 4);
			gap = (ph == RAND_PHASES - 1) ? $urandom_range(25, 120) : $urandom_range(0, 24);
			// upper data bits are junk for the debounce register
			write_reg(REG_DEBOUNCE, {2'($urandom_range(0, 3)), 8'(deb)});
			write_reg(REG_GAP, 10'(gap));
			sent = 0;
			while (sent < PHASE_TICKS) begin
				if ($urandom_range(0, 4) != 0) begin
					send_run(1'b1, $urandom_range(1, 2 * deb + 3), sent);
					if ($urandom_range(0, 1) != 0)
						len = $urandom_range(1, deb + gap / 2 + 2);
					else
						len = $urandom_range(gap, gap + 2 * deb + 4);
					send_run(1'b0, len, sent);
				end else begin
					len = $urandom_range(1, 6);
					repeat (len) send_tick(1'($urandom_range(0, 1)), 1'b0, EV_NONE);
					sent += len;
				end
			end
		end

		drain_events();
		repeat (10) @(posedge clk);
		$display("covered %0d ticks, %0d register writes, %0d single and %0d double presses",
			n_ticks, n_writes, n_single, n_double);
		$display("mismatches: %0d", mismatch_cnt);
		if (mismatch_cnt == 0 && due_events.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#40000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/bcc_pkg.sv
src/bcc_cfg_regs.sv
src/bcc_engine.sv
src/button_click_classifier.sv
bench/tb_button_click_classifier.sv
